>>> rtl/npp_pkg.sv
// ----------------------------------------------------------------------------
// npp_pkg
// Shared types and constants for the nearest path point block.
// ----------------------------------------------------------------------------
package npp_pkg;

  localparam int MAX_POINTS_DEFAULT = 1024;

  localparam int COORD_W = 32;
  localparam int HEAD_W  = 16;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  // Quarter-wave sine polynomial coefficients, Q30.
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598669;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026996;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  localparam logic [33:0] Q30_ONE      = 34'h0_4000_0000;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_LOAD,
    ST_DIFF,
    ST_SIN,
    ST_COS,
    ST_MUL,
    ST_SUM,
    ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    SS_SQUARE,
    SS_C7,
    SS_C5,
    SS_C3,
    SS_C1,
    SS_SCALE
  } sin_step_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } sin_res_t;

endpackage

>>> rtl/npp_ram.sv
// ----------------------------------------------------------------------------
// npp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/npp_sine.sv
// ----------------------------------------------------------------------------
// npp_sine
// Iterative Q30 sine of a binary angle: one shared multiplier evaluates the
// quarter-wave polynomial in six steps and reports magnitude and sign.
// ----------------------------------------------------------------------------
module npp_sine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [15:0]       angle,
  output logic              done,
  output npp_pkg::sin_res_t res
);

  import npp_pkg::*;

  logic        busy;
  sin_step_t   step;
  sin_step_t   step_next;
  logic [14:0] rr;
  logic [31:0] t;
  logic [31:0] t2;
  logic [31:0] p;
  logic        neg;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] coef;
  logic [63:0] prod;
  logic [33:0] sh;

  always_comb begin
    rr = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  end

  always_comb begin
    step_next = SS_SQUARE;
    op_a      = t2;
    op_b      = p;
    coef      = SIN_C1;
    case (step)
      SS_SQUARE: begin
        step_next = SS_C7;
        op_a      = t;
        op_b      = t;
      end
      SS_C7: begin
        step_next = SS_C5;
        op_b      = SIN_C9;
        coef      = SIN_C7;
      end
      SS_C5: begin
        step_next = SS_C3;
        coef      = SIN_C5;
      end
      SS_C3: begin
        step_next = SS_C1;
        coef      = SIN_C3;
      end
      SS_C1: begin
        step_next = SS_SCALE;
        coef      = SIN_C1;
      end
      SS_SCALE: begin
        step_next = SS_SQUARE;
        op_a      = t;
      end
      default: begin
        step_next = SS_SQUARE;
      end
    endcase
  end

  assign prod = {32'b0, op_a} * {32'b0, op_b};
  assign sh   = prod[63:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= SS_SQUARE;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= SS_SQUARE;
      end else if (busy) begin
        step <= step_next;
        if (step == SS_SCALE) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t   <= {1'b0, rr, 16'b0};
      neg <= angle[15];
    end else if (busy) begin
      case (step)
        SS_SQUARE: begin
          t2 <= sh[31:0];
        end
        SS_C7, SS_C5, SS_C3, SS_C1: begin
          p <= coef - sh[31:0];
        end
        SS_SCALE: begin
          res.neg <= neg;
          res.mag <= (sh > Q30_ONE) ? Q30_ONE[30:0] : sh[30:0];
        end
        default: begin
          t2 <= t2;
        end
      endcase
    end
  end

endmodule

>>> rtl/nearest_path_point_cross_track.sv
// ----------------------------------------------------------------------------
// nearest_path_point_cross_track
// Path point table with nearest point search and cross-track offset.
// ----------------------------------------------------------------------------
// Write words (op 0) store one path point in the table;
// writes to a slot at or above MAX_POINTS are dropped. A query word (op 1)
// scans slots 0 to point_count-1 (at most MAX_POINTS) through the read
// port of the point memory, one slot per cycle, finds the nearest point by
// squared distance (the later slot wins a tie), reads that point back and
// computes the cross-track offset with an iterative sine unit run twice.
// The input is stalled while a query is in progress, and a finished
// result waits in the output register while the next word is taken.
// With point_count 0 the result has found low and all other fields zero.
// ----------------------------------------------------------------------------
module nearest_path_point_cross_track #(
  parameter int MAX_POINTS = npp_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [npp_pkg::COUNT_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   op,
  input  logic [npp_pkg::INDEX_W-1:0]            index,
  input  logic signed [npp_pkg::COORD_W-1:0]     coord_x,
  input  logic signed [npp_pkg::COORD_W-1:0]     coord_y,
  input  logic signed [npp_pkg::HEAD_W-1:0]      heading_in,
  input  logic signed [npp_pkg::COORD_W-1:0]     arc_in,
  input  logic signed [npp_pkg::COORD_W-1:0]     extra_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   found,
  output logic [npp_pkg::INDEX_W-1:0]            best_index,
  output logic signed [npp_pkg::COORD_W-1:0]     best_x,
  output logic signed [npp_pkg::COORD_W-1:0]     best_y,
  output logic signed [npp_pkg::HEAD_W-1:0]      best_heading,
  output logic signed [npp_pkg::COORD_W-1:0]     best_arc,
  output logic signed [npp_pkg::COORD_W-1:0]     best_extra,
  output logic signed [npp_pkg::COORD_W-1:0]     lateral_offset
);

  import npp_pkg::*;

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int GEO_W  = 2 * COORD_W;
  localparam int ATTR_W = HEAD_W + 2 * COORD_W;
  localparam logic [64:0] ROUND_HALF = 65'h0_0000_0000_2000_0000;

  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    logic [32:0] nd;
    d  = {a[31], a} - {b[31], b};
    nd = -d;
    return {d[32], d[32] ? nd[31:0] : d[31:0]};
  endfunction

  state_t            state;
  state_t            state_next;
  logic [COUNT_W-1:0] point_count;
  logic [CW-1:0]     scan_n;
  logic [CW-1:0]     issue_cnt;
  logic [31:0]       tx;
  logic [31:0]       ty;

  logic              in_take;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic              scan_rd;
  logic [AW-1:0]     rd_addr;
  logic [GEO_W-1:0]  geo_rdata;
  logic [ATTR_W-1:0] attr_rdata;

  logic              v0;
  logic              va;
  logic              vb;
  logic [AW-1:0]     addr0;
  logic [AW-1:0]     addr_a;
  logic [AW-1:0]     addr_b;
  logic [32:0]       scan_dx;
  logic [32:0]       scan_dy;
  logic [31:0]       ax;
  logic [31:0]       ay;
  logic [63:0]       sq_x;
  logic [63:0]       sq_y;
  logic [63:0]       sx;
  logic [63:0]       sy;
  logic [64:0]       sq_dist;
  logic              take_best;
  logic              found_any;
  logic [64:0]       best_dist;
  logic [AW-1:0]     best_addr;

  logic [31:0]       bx;
  logic [31:0]       by;
  logic [15:0]       bh;
  logic [31:0]       barc;
  logic [31:0]       bext;
  logic [32:0]       pt_dx;
  logic [32:0]       pt_dy;
  logic [31:0]       dx_mag;
  logic [31:0]       dy_mag;
  logic              dx_neg;
  logic              dy_neg;

  logic              sin_start;
  logic [15:0]       sin_angle;
  logic              sin_done;
  sin_res_t          sin_out;
  sin_res_t          s_res;
  sin_res_t          c_res;

  logic [63:0]       prod_c;
  logic [63:0]       prod_s;
  logic [63:0]       term_c;
  logic [63:0]       term_s;
  logic [64:0]       sum;
  logic [34:0]       shifted;
  logic [31:0]       off_sat;
  logic [31:0]       off_reg;
  logic              load_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign wr_en     = in_take && !op && (32'(index) < 32'(MAX_POINTS));
  assign wr_addr   = AW'(index);
  assign load_out  = (state == ST_RESULT) && (!out_valid || !out_stall);

  npp_ram #(
    .WIDTH (GEO_W),
    .DEPTH (MAX_POINTS)
  ) u_geo_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({coord_x, coord_y}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (geo_rdata)
  );

  npp_ram #(
    .WIDTH (ATTR_W),
    .DEPTH (MAX_POINTS)
  ) u_attr_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({heading_in, arc_in, extra_in}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (attr_rdata)
  );

  npp_sine u_sine (
    .clk   (clk),
    .rst   (rst),
    .start (sin_start),
    .angle (sin_angle),
    .done  (sin_done),
    .res   (sin_out)
  );

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    scan_rd    = 1'b0;
    rd_addr    = issue_cnt[AW-1:0];
    sin_start  = 1'b0;
    sin_angle  = bh;
    case (state)
      ST_IDLE: begin
        if (in_take && op) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_cnt != scan_n) begin
          rd_en   = 1'b1;
          scan_rd = 1'b1;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v0 && !va && !vb) begin
          state_next = found_any ? ST_FETCH : ST_RESULT;
        end
      end
      ST_FETCH: begin
        rd_en      = 1'b1;
        rd_addr    = best_addr;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        sin_start  = 1'b1;
        state_next = ST_SIN;
      end
      ST_SIN: begin
        if (sin_done) begin
          sin_start  = 1'b1;
          sin_angle  = bh + QUARTER_TURN;
          state_next = ST_COS;
        end
      end
      ST_COS: begin
        if (sin_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign scan_dx   = abs_diff(tx, geo_rdata[63:32]);
  assign scan_dy   = abs_diff(ty, geo_rdata[31:0]);
  assign sq_x      = {32'b0, ax} * {32'b0, ax};
  assign sq_y      = {32'b0, ay} * {32'b0, ay};
  assign sq_dist   = {1'b0, sx} + {1'b0, sy};
  assign take_best = vb && (!found_any || (sq_dist <= best_dist));

  assign pt_dx  = abs_diff(tx, bx);
  assign pt_dy  = abs_diff(ty, by);
  assign prod_c = {33'b0, c_res.mag} * {32'b0, dy_mag};
  assign prod_s = {33'b0, s_res.mag} * {32'b0, dx_mag};

  assign sum     = {term_c[63], term_c} - {term_s[63], term_s} + ROUND_HALF;
  assign shifted = sum[64:30];

  always_comb begin
    if (!shifted[34] && (shifted[33:31] != 3'b000)) begin
      off_sat = 32'h7FFF_FFFF;
    end else if (shifted[34] && (shifted[33:31] != 3'b111)) begin
      off_sat = 32'h8000_0000;
    end else begin
      off_sat = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      out_valid   <= 1'b0;
      v0          <= 1'b0;
      va          <= 1'b0;
      vb          <= 1'b0;
      found_any   <= 1'b0;
      issue_cnt   <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        point_count <= cfg_data;
      end
      v0 <= scan_rd;
      va <= v0;
      vb <= va;
      if (in_take && op) begin
        found_any <= 1'b0;
        issue_cnt <= '0;
      end else begin
        if (scan_rd) begin
          issue_cnt <= issue_cnt + CW'(1);
        end
        if (take_best) begin
          found_any <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && op) begin
      tx     <= coord_x;
      ty     <= coord_y;
      scan_n <= (32'(point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(point_count);
    end
    addr0  <= issue_cnt[AW-1:0];
    addr_a <= addr0;
    addr_b <= addr_a;
    ax     <= scan_dx[31:0];
    ay     <= scan_dy[31:0];
    sx     <= sq_x;
    sy     <= sq_y;
    if (take_best) begin
      best_dist <= sq_dist;
      best_addr <= addr_b;
    end
    if (state == ST_LOAD) begin
      bx   <= geo_rdata[63:32];
      by   <= geo_rdata[31:0];
      bh   <= attr_rdata[79:64];
      barc <= attr_rdata[63:32];
      bext <= attr_rdata[31:0];
    end
    if (state == ST_DIFF) begin
      dx_mag <= pt_dx[31:0];
      dx_neg <= pt_dx[32];
      dy_mag <= pt_dy[31:0];
      dy_neg <= pt_dy[32];
    end
    if ((state == ST_SIN) && sin_done) begin
      s_res <= sin_out;
    end
    if ((state == ST_COS) && sin_done) begin
      c_res <= sin_out;
    end
    if (state == ST_MUL) begin
      term_c <= (c_res.neg ^ dy_neg) ? -prod_c : prod_c;
      term_s <= (s_res.neg ^ dx_neg) ? -prod_s : prod_s;
    end
    if (state == ST_SUM) begin
      off_reg <= off_sat;
    end
    if (load_out) begin
      found          <= found_any;
      best_index     <= found_any ? INDEX_W'(best_addr) : '0;
      best_x         <= found_any ? bx : '0;
      best_y         <= found_any ? by : '0;
      best_heading   <= found_any ? bh : '0;
      best_arc       <= found_any ? barc : '0;
      best_extra     <= found_any ? bext : '0;
      lateral_offset <= found_any ? off_reg : '0;
    end
  end

endmodule
